// ===== design/kmep_pkg.sv =====
// shared types and constants of the key matrix event pacer
package kmep_pkg;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_MAP  = 2'd2;

	localparam logic [1:0] STATUS_CLOSED   = 2'd0;
	localparam logic [1:0] STATUS_OPENED   = 2'd1;
	localparam logic [1:0] STATUS_UNMAPPED = 2'd2;
	localparam logic [1:0] STATUS_DROPPED  = 2'd3;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_GAP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAP = 1'd1;

	localparam logic [7:0] PRESS_GAP_RST   = 8'd40;
	localparam logic [7:0] RELEASE_GAP_RST = 8'd20;

	// map_slot is six bits wide, so no more entries can ever be written
	localparam int MAP_SLOTS = 64;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] key_code;
		logic        pressed;
		logic [5:0]  map_slot;
		logic [5:0]  map_row_line;
		logic [5:0]  map_col_line;
		logic        map_modifier;
		logic        map_valid;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  line_a;
		logic [5:0]  line_b;
		logic [15:0] event_code;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic        pressed;
		logic [15:0] code;
	} evt_t;

	typedef struct packed {
		logic [15:0] code;
		logic [5:0]  row;
		logic [5:0]  col;
		logic        modifier;
	} map_ent_t;

	typedef struct packed {
		logic       en;
		logic [5:0] slot;
		logic       valid;
		map_ent_t   ent;
	} map_wr_t;

	typedef struct packed {
		logic strobe;
		logic matched;
		logic modifier;
		logic pressed;
	} done_t;

endpackage

// ===== design/kmep_fifo.sv =====
// event queue between the pacing front and the map scanning back
module kmep_fifo #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  kmep_pkg::evt_t               push_data,
	input  logic                         pop,
	output kmep_pkg::evt_t               head,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	kmep_pkg::evt_t mem [DEPTH];
	kmep_pkg::evt_t head_q;
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= ptr_next(wr_q);
			if (pop)
				rd_q <= ptr_next(rd_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_data;
		if (pop)
			head_q <= mem[rd_q];
	end

	assign head  = head_q;
	assign count = count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("event queue count beyond depth");
`endif

endmodule

// ===== design/kmep_front.sv =====
// front: takes command words, keeps the tick pacing and the gap registers
module kmep_front #(
	parameter int QUEUE_DEPTH = 64,
	parameter int MAP_ENTRIES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  kmep_pkg::in_word_t                 cmd,
	input  logic                               cfg_we,
	input  logic [kmep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_wdata,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_level,
	input  logic                               back_busy,
	input  kmep_pkg::done_t                    done,
	output logic                               busy,
	output logic                               push,
	output kmep_pkg::evt_t                     push_data,
	output logic                               pop,
	output logic                               exec_go,
	output kmep_pkg::map_wr_t                  map_wr,
	output logic                               drop_valid,
	output kmep_pkg::out_word_t                drop_word
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic       accept;
	logic       is_tick;
	logic       is_key;
	logic       is_map;
	logic       full;
	logic       fire;
	logic [7:0] first_gap;
	logic [7:0] since_q;
	logic [7:0] wait_rem_q;
	logic       wait_active_q;
	logic       exec_wait_q;
	logic [7:0] press_gap_q;
	logic [7:0] release_gap_q;
	logic       go_q;
	logic       drop_valid_q;
	kmep_pkg::out_word_t drop_word_q;

	always_comb begin
		accept    = start && !busy;
		is_tick   = accept && (cmd.kind == kmep_pkg::KIND_TICK);
		is_key    = accept && (cmd.kind == kmep_pkg::KIND_KEY);
		is_map    = accept && (cmd.kind == kmep_pkg::KIND_MAP);
		full      = (queue_level == CW'(QUEUE_DEPTH));
		fire      = is_tick && wait_active_q && (wait_rem_q <= 8'd1);
		pop       = fire && (queue_level != '0);
		push      = is_key && !full;
		push_data = '{pressed: cmd.pressed, code: cmd.key_code};
		first_gap = (press_gap_q > since_q) ? press_gap_q - since_q : 8'd0;
		map_wr.en    = is_map && (32'(cmd.map_slot) < MAP_ENTRIES);
		map_wr.slot  = cmd.map_slot;
		map_wr.valid = cmd.map_valid;
		map_wr.ent   = '{code: cmd.key_code, row: cmd.map_row_line,
			col: cmd.map_col_line, modifier: cmd.map_modifier};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q       <= '0;
			wait_rem_q    <= '0;
			wait_active_q <= 1'b0;
			exec_wait_q   <= 1'b0;
			press_gap_q   <= kmep_pkg::PRESS_GAP_RST;
			release_gap_q <= kmep_pkg::RELEASE_GAP_RST;
			go_q          <= 1'b0;
			drop_valid_q  <= 1'b0;
		end else begin
			go_q         <= pop;
			drop_valid_q <= is_key && full;
			if (cfg_we) begin
				if (cfg_index == kmep_pkg::REG_PRESS_GAP)
					press_gap_q <= cfg_wdata;
				if (cfg_index == kmep_pkg::REG_RELEASE_GAP)
					release_gap_q <= cfg_wdata;
			end
			if (is_tick) begin
				if (since_q != 8'hFF)
					since_q <= since_q + 1'b1;
				if (wait_active_q) begin
					if (wait_rem_q <= 8'd1) begin
						if (queue_level == '0) begin
							wait_active_q <= 1'b0;
							wait_rem_q    <= '0;
						end else begin
							exec_wait_q <= 1'b1;
						end
					end else begin
						wait_rem_q <= wait_rem_q - 1'b1;
					end
				end
			end
			if (push && !wait_active_q) begin
				wait_active_q <= 1'b1;
				wait_rem_q    <= first_gap;
			end
			// execution finished: the queue count already reflects the pop
			if (done.strobe) begin
				exec_wait_q <= 1'b0;
				if (done.matched)
					since_q <= '0;
				if (queue_level != '0) begin
					wait_active_q <= 1'b1;
					if (!done.matched || done.modifier)
						wait_rem_q <= '0;
					else
						wait_rem_q <= done.pressed ? press_gap_q : release_gap_q;
				end else begin
					wait_active_q <= 1'b0;
					wait_rem_q    <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_key)
			drop_word_q <= '{status: kmep_pkg::STATUS_DROPPED, line_a: 6'd0,
				line_b: 6'd0, event_code: cmd.key_code, last: 1'b1};
	end

	assign busy       = exec_wait_q || back_busy;
	assign exec_go    = go_q;
	assign drop_valid = drop_valid_q;
	assign drop_word  = drop_word_q;

`ifndef NO_ASSERTIONS
	a_exec_has_wait: assert property (@(posedge clk) disable iff (!arst_n)
		exec_wait_q |-> wait_active_q)
		else $error("execution pending without an active wait");
`endif

endmodule

// ===== design/kmep_exec.sv =====
// back: scans the key map for the head event and emits the crosspoint words
module kmep_exec #(
	parameter int MAP_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  kmep_pkg::evt_t       head,
	input  kmep_pkg::map_wr_t    map_wr,
	output logic                 busy,
	output kmep_pkg::done_t      done,
	output logic                 res_valid,
	output kmep_pkg::out_word_t  res
);

	localparam int MAP_DEPTH = (MAP_ENTRIES < kmep_pkg::MAP_SLOTS) ?
		MAP_ENTRIES : kmep_pkg::MAP_SLOTS;
	localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int IW  = $clog2(MAP_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;

	kmep_pkg::map_ent_t map_mem [MAP_DEPTH];
	logic               valid_q [MAP_DEPTH];

	logic [1:0]          state_q;
	logic [IW-1:0]       idx_q;
	logic                chk_s1;
	logic                ent_vld_s1;
	kmep_pkg::map_ent_t  ent_s1;
	logic [15:0]         code_q;
	logic                pressed_q;
	kmep_pkg::map_ent_t  pend_q;
	logic                have_pend_q;
	logic                mod_q;
	logic                res_valid_q;
	kmep_pkg::out_word_t res_q;
	kmep_pkg::done_t     done_q;
	logic                scan_rd;
	logic                hit;

	always_comb begin
		scan_rd = (state_q == ST_SCAN) && (idx_q != IW'(MAP_DEPTH));
		hit     = chk_s1 && ent_vld_s1 && (ent_s1.code == code_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			chk_s1      <= 1'b0;
			have_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
			done_q      <= '0;
			for (int i = 0; i < MAP_DEPTH; i++)
				valid_q[i] <= 1'b0;
		end else begin
			res_valid_q   <= 1'b0;
			done_q.strobe <= 1'b0;
			chk_s1        <= scan_rd;
			if (map_wr.en)
				valid_q[map_wr.slot[MAW-1:0]] <= map_wr.valid;
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						have_pend_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_rd)
						idx_q <= idx_q + 1'b1;
					else
						state_q <= ST_LAST;
				end
				ST_LAST: begin
					res_valid_q     <= 1'b1;
					done_q.strobe   <= 1'b1;
					done_q.matched  <= have_pend_q;
					done_q.modifier <= mod_q;
					done_q.pressed  <= pressed_q;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// a match flushes the one held back, so the final word can carry last
			if (hit) begin
				have_pend_q <= 1'b1;
				if (have_pend_q)
					res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (map_wr.en)
			map_mem[map_wr.slot[MAW-1:0]] <= map_wr.ent;
		if (scan_rd) begin
			ent_s1     <= map_mem[idx_q[MAW-1:0]];
			ent_vld_s1 <= valid_q[idx_q[MAW-1:0]];
		end
		if ((state_q == ST_IDLE) && go) begin
			code_q    <= head.code;
			pressed_q <= head.pressed;
		end
		if (hit) begin
			pend_q <= ent_s1;
			mod_q  <= ent_s1.modifier;
			if (have_pend_q)
				res_q <= '{status: pressed_q ? kmep_pkg::STATUS_CLOSED :
					kmep_pkg::STATUS_OPENED, line_a: pend_q.row, line_b: pend_q.col,
					event_code: code_q, last: 1'b0};
		end
		if (state_q == ST_LAST) begin
			if (have_pend_q)
				res_q <= '{status: pressed_q ? kmep_pkg::STATUS_CLOSED :
					kmep_pkg::STATUS_OPENED, line_a: pend_q.row, line_b: pend_q.col,
					event_code: code_q, last: 1'b1};
			else
				res_q <= '{status: kmep_pkg::STATUS_UNMAPPED, line_a: 6'd0,
					line_b: 6'd0, event_code: code_q, last: 1'b1};
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q.strobe |-> (res_valid_q && res_q.last))
		else $error("scan finished without a final word");
	a_res_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(state_q != ST_IDLE))
		else $error("result word outside a scan");
`endif

endmodule

// ===== design/key_matrix_event_pacer.sv =====
// top level of the key matrix event pacer
// a tick, key or map word is taken while busy is low; busy stays low after a key or map word
// a tick that fires an event holds busy until the key map scan over N = min(MAP_ENTRIES, 64)
// entries, reading one memory entry per cycle, has finished
// crosspoint words follow the scan, the final one with last set
// a dropped event gives its word in the cycle after it is taken
// arst_n clears the queue, the map valid bits, the pacing state and sets gaps to 40 and 20
module key_matrix_event_pacer #(
	parameter int QUEUE_DEPTH = 64,
	parameter int MAP_ENTRIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  kmep_pkg::in_word_t               cmd,
	output logic                             busy,
	output logic                             result_valid,
	output kmep_pkg::out_word_t              result,
	input  logic                             cfg_we,
	input  logic [kmep_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_wdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                back_busy;
	logic                push;
	logic                pop;
	logic                exec_go;
	logic                drop_valid;
	logic                res_valid;
	logic [CW-1:0]       queue_level;
	kmep_pkg::evt_t      push_data;
	kmep_pkg::evt_t      head;
	kmep_pkg::map_wr_t   map_wr;
	kmep_pkg::done_t     done;
	kmep_pkg::out_word_t drop_word;
	kmep_pkg::out_word_t res;

	kmep_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.queue_level (queue_level),
		.back_busy   (back_busy),
		.done        (done),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data),
		.pop         (pop),
		.exec_go     (exec_go),
		.map_wr      (map_wr),
		.drop_valid  (drop_valid),
		.drop_word   (drop_word)
	);

	kmep_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (queue_level)
	);

	kmep_exec #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (exec_go),
		.head      (head),
		.map_wr    (map_wr),
		.busy      (back_busy),
		.done      (done),
		.res_valid (res_valid),
		.res       (res)
	);

	always_comb begin
		result_valid = res_valid || drop_valid;
		result       = res_valid ? res : drop_word;
	end

`ifndef NO_ASSERTIONS
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && drop_valid))
		else $error("scan word and drop word in the same cycle");
`endif

endmodule
